@@ src/rti_pkg.sv @@
`default_nettype none
package rti_pkg;
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int EPS_WIDTH   = 31;
    localparam int EW  = COORD_WIDTH + 1;
    localparam int MW  = 2 * COORD_WIDTH + 2;
    localparam int PW  = 2 * COORD_WIDTH + 4;
    localparam int LW  = COORD_WIDTH + 2;
    localparam int HW  = PW - LW;
    localparam int DW  = 3 * COORD_WIDTH + 8;
    localparam int CPW = EPS_WIDTH + LW;
    localparam int XW  = EPS_WIDTH + 3 * LW + 1;
    localparam int IDX_WIDTH = 3;
    localparam int CFG_WIDTH = 32;
    localparam int IN_FIELDS = 12;

    localparam logic [IDX_WIDTH-1:0] REG_DIR_X   = 3'd0;
    localparam logic [IDX_WIDTH-1:0] REG_DIR_Y   = 3'd1;
    localparam logic [IDX_WIDTH-1:0] REG_DIR_Z   = 3'd2;
    localparam logic [IDX_WIDTH-1:0] REG_EPSILON = 3'd3;

    typedef logic signed [EW-1:0] t_edge;
    typedef logic signed [PW-1:0] t_cross;
    typedef logic signed [DW-1:0] t_dot;
endpackage
`default_nettype wire

@@ src/rti_dot3.sv @@
`default_nettype none
module rti_dot3 (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire rti_pkg::t_edge  i_a [3],
    input  wire rti_pkg::t_cross i_b [3],
    output rti_pkg::t_dot        o_sum
);
    localparam int PLW = rti_pkg::EW + rti_pkg::LW + 1;
    localparam int PHW = rti_pkg::EW + rti_pkg::HW;

    logic signed [PLW-1:0] r_lo [3];
    logic signed [PHW-1:0] r_hi [3];
    rti_pkg::t_dot         r_prod [3];
    rti_pkg::t_dot         r_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_lo[k] <= i_a[k] * $signed({1'b0, i_b[k][rti_pkg::LW-1:0]});
                r_hi[k] <= i_a[k] * $signed(i_b[k][rti_pkg::PW-1:rti_pkg::LW]);
                r_prod[k] <= (rti_pkg::DW'(r_hi[k]) <<< rti_pkg::LW)
                             + rti_pkg::DW'(r_lo[k]);
            end
            r_sum <= r_prod[0] + r_prod[1] + r_prod[2];
        end
    end

    assign o_sum = r_sum;
endmodule
`default_nettype wire

@@ src/ray_triangle_intersect_test_unit.sv @@
// Channel | Direction | Payload
// s_axis  | in        | tdata[383:0]: org_x,org_y,org_z,a_x..a_z,b_x..b_z,c_x..c_z
// m_axis  | out       | tdata[7:0]: hit, zero pad
// cfg     | in        | index: dir_x, dir_y, dir_z, epsilon; data 32 bits
// One item per cycle while m_axis is not stalled; every item gives one result.
// Latency is set by the split wide multiplies of the cross and dot products.
// Reset clears valid bits and loads the register defaults.
// A stall on m_axis freezes the whole pipeline; nothing is lost or repeated.
`default_nettype none
module ray_triangle_intersect_test_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [rti_pkg::IN_FIELDS*rti_pkg::COORD_WIDTH-1:0] s_axis_tdata,  // org_x,org_y,org_z,a_x,a_y,a_z,b_x,..,c_z
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [7:0]        m_axis_tdata,  // hit, zeros
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [rti_pkg::IDX_WIDTH-1:0] i_cfg_index,
    input  wire logic [rti_pkg::CFG_WIDTH-1:0] i_cfg_data
);
    localparam int CW  = rti_pkg::COORD_WIDTH;
    localparam int FB  = rti_pkg::FRAC_BITS;
    localparam int EPW = rti_pkg::EPS_WIDTH;
    localparam int DW  = rti_pkg::DW;
    localparam int LW  = rti_pkg::LW;
    localparam int XW  = rti_pkg::XW;
    localparam int NS  = 10;

    logic signed [CW-1:0]  r_dir [3];
    logic [EPW-1:0]        r_eps;
    logic [NS-1:0]         r_v;
    logic                  en;

    logic signed [CW-1:0]  f [rti_pkg::IN_FIELDS];
    rti_pkg::t_edge        r1_e1 [3], r1_e2 [3], r1_t [3];
    rti_pkg::t_edge        r2_e1 [3], r2_e2 [3], r2_t [3];
    rti_pkg::t_edge        r3_e1 [3], r3_e2 [3], r3_t [3];
    logic signed [rti_pkg::MW-1:0] r2_pm [6], r2_qm [6];
    rti_pkg::t_cross       r3_p [3], r3_q [3];
    rti_pkg::t_edge        dir_e [3];
    rti_pkg::t_dot         det, uu, vv, tt;
    rti_pkg::t_dot         r7_det, r7_u, r7_v, r7_t, r8_t;
    logic                  r8_pass, r9_pass;
    logic [rti_pkg::CPW-1:0] r8_c [3];
    logic [XW-1:0]         r9_ed;
    logic signed [XW:0]    r9_t16;
    logic                  r_hit;

    logic signed [DW-1:0]  eps_sh;
    logic signed [DW:0]    uv;

    assign en = !r_v[NS-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign o_cfg_ready = 1'b1;
    assign m_axis_tvalid = r_v[NS-1];
    assign m_axis_tdata = {7'd0, r_hit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir[0] <= CW'(1 << FB);
            r_dir[1] <= '0;
            r_dir[2] <= '0;
            r_eps    <= EPW'(66);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rti_pkg::REG_DIR_X:   r_dir[0] <= $signed(i_cfg_data[CW-1:0]);
                rti_pkg::REG_DIR_Y:   r_dir[1] <= $signed(i_cfg_data[CW-1:0]);
                rti_pkg::REG_DIR_Z:   r_dir[2] <= $signed(i_cfg_data[CW-1:0]);
                rti_pkg::REG_EPSILON: r_eps <= i_cfg_data[EPW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NS-2:0], s_axis_tvalid};
        end
    end

    always_comb begin
        for (int k = 0; k < rti_pkg::IN_FIELDS; k++) begin
            f[k] = $signed(s_axis_tdata[k*CW +: CW]);
        end
        for (int k = 0; k < 3; k++) begin
            dir_e[k] = rti_pkg::EW'(r_dir[k]);
        end
        eps_sh = $signed({{(DW-EPW-2*FB){1'b0}}, r_eps, {(2*FB){1'b0}}});
        uv = (DW+1)'(r7_u) + (DW+1)'(r7_v);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r1_e1[k] <= rti_pkg::EW'(f[6+k]) - rti_pkg::EW'(f[3+k]);
                r1_e2[k] <= rti_pkg::EW'(f[9+k]) - rti_pkg::EW'(f[3+k]);
                r1_t[k]  <= rti_pkg::EW'(f[k])   - rti_pkg::EW'(f[3+k]);
            end
            r2_e1 <= r1_e1;
            r2_e2 <= r1_e2;
            r2_t  <= r1_t;
            for (int k = 0; k < 3; k++) begin
                r2_pm[2*k]   <= dir_e[(k+1)%3] * r1_e2[(k+2)%3];
                r2_pm[2*k+1] <= dir_e[(k+2)%3] * r1_e2[(k+1)%3];
                r2_qm[2*k]   <= r1_t[(k+1)%3] * r1_e1[(k+2)%3];
                r2_qm[2*k+1] <= r1_t[(k+2)%3] * r1_e1[(k+1)%3];
            end
            r3_e1 <= r2_e1;
            r3_e2 <= r2_e2;
            r3_t  <= r2_t;
            for (int k = 0; k < 3; k++) begin
                r3_p[k] <= rti_pkg::PW'(r2_pm[2*k]) - rti_pkg::PW'(r2_pm[2*k+1]);
                r3_q[k] <= rti_pkg::PW'(r2_qm[2*k]) - rti_pkg::PW'(r2_qm[2*k+1]);
            end
            if (det[DW-1]) begin
                r7_det <= -det;
                r7_u   <= -uu;
                r7_v   <= -vv;
                r7_t   <= -tt;
            end else begin
                r7_det <= det;
                r7_u   <= uu;
                r7_v   <= vv;
                r7_t   <= tt;
            end
            r8_pass <= (r7_det != '0) && !(r7_det < eps_sh) && !r7_u[DW-1]
                       && !(r7_det < r7_u) && !r7_v[DW-1]
                       && !((DW+1)'(r7_det) < uv);
            for (int k = 0; k < 3; k++) begin
                r8_c[k] <= r_eps * r7_det[k*LW +: LW];
            end
            r8_t <= r7_t;
            r9_pass <= r8_pass;
            r9_ed <= XW'(r8_c[0]) + (XW'(r8_c[1]) << LW) + (XW'(r8_c[2]) << (2*LW));
            r9_t16 <= (XW+1)'(r8_t) <<< FB;
            r_hit <= r9_pass && ($signed({1'b0, r9_ed}) < r9_t16);
        end
    end

    rti_dot3 u_det (.i_clk(i_clk), .i_en(en), .i_a(r3_e1), .i_b(r3_p), .o_sum(det));
    rti_dot3 u_uu  (.i_clk(i_clk), .i_en(en), .i_a(r3_t),  .i_b(r3_p), .o_sum(uu));
    rti_dot3 u_vv  (.i_clk(i_clk), .i_en(en), .i_a(dir_e), .i_b(r3_q), .o_sum(vv));
    rti_dot3 u_tt  (.i_clk(i_clk), .i_en(en), .i_a(r3_e2), .i_b(r3_q), .o_sum(tt));
endmodule
`default_nettype wire

@@ src/rti_checker.sv @@
`default_nettype none
module rti_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       o_cfg_ready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready not tied to output stall");
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("valid after reset");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'd0) && o_cfg_ready)
        else $error("bad padding or config ready");
endmodule

bind ray_triangle_intersect_test_unit rti_checker u_rti_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .o_cfg_ready(o_cfg_ready)
);
`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [191:0] wide_t;
    localparam int Q = 1 << rti_pkg::FRAC_BITS;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [383:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [rti_pkg::IDX_WIDTH-1:0] i_cfg_index = '0;
    logic [rti_pkg::CFG_WIDTH-1:0] i_cfg_data = '0;

    ray_triangle_intersect_test_unit DUT (.*);

    always #5 i_clk = ~i_clk;

    logic [31:0] dir_x = 32'd65536, dir_y = '0, dir_z = '0;
    logic [30:0] eps = 31'd66;
    bit          hit_q[$];
    int          errors = 0;
    bit          calm = 0;
    bit          hold_req = 0;

    function automatic wide_t coord(logic [31:0] x);
        return {{160{x[31]}}, x};
    endfunction

    function automatic bit hit_of(logic [383:0] d);
        wide_t ox, oy, oz, ax, ay, az, e1x, e1y, e1z, e2x, e2y, e2z, tx, ty, tz;
        wide_t dx, dy, dz, px, py, pz, qx, qy, qz, det, uu, vv, tt, ew;
        ox = coord(d[0+:32]);   oy = coord(d[32+:32]);  oz = coord(d[64+:32]);
        ax = coord(d[96+:32]);  ay = coord(d[128+:32]); az = coord(d[160+:32]);
        e1x = coord(d[192+:32]) - ax; e1y = coord(d[224+:32]) - ay;
        e1z = coord(d[256+:32]) - az; e2x = coord(d[288+:32]) - ax;
        e2y = coord(d[320+:32]) - ay; e2z = coord(d[352+:32]) - az;
        tx = ox - ax; ty = oy - ay; tz = oz - az;
        dx = coord(dir_x); dy = coord(dir_y); dz = coord(dir_z);
        ew = {161'b0, eps};
        px = dy * e2z - dz * e2y; py = dz * e2x - dx * e2z; pz = dx * e2y - dy * e2x;
        qx = ty * e1z - tz * e1y; qy = tz * e1x - tx * e1z; qz = tx * e1y - ty * e1x;
        det = e1x * px + e1y * py + e1z * pz;
        uu = tx * px + ty * py + tz * pz;
        vv = dx * qx + dy * qy + dz * qz;
        tt = e2x * qx + e2y * qy + e2z * qz;
        if (det < 0) begin
            det = -det; uu = -uu; vv = -vv; tt = -tt;
        end
        if (det == 0 || det < (ew <<< (2 * rti_pkg::FRAC_BITS))) return 0;
        if (uu < 0 || uu > det || vv < 0 || uu + vv > det) return 0;
        return (ew * det) < (tt <<< rti_pkg::FRAC_BITS);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            hit_q.insert(hit_q.size(), hit_of(s_axis_tdata));
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (hit_q.size() == 0)
                report_mismatch("result with no item pending", 0, m_axis_tdata[0]);
            else
                check_hit(hit_q.pop_front());
        end
    end

    task automatic report_mismatch(string what, int want, int got);
        $display("mismatch at %0t: %s (expected %0d, got %0d)", $realtime, what, want, got);
        errors++;
    endtask

    task automatic check_hit(bit want);
        if (m_axis_tdata[0] !== want)
            report_mismatch("hit", want, m_axis_tdata[0]);
    endtask

    // receiver: random stalls, plus a long hold on request
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                stall = 300;
                hold_req = 0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else if (!calm && $urandom_range(7) == 0) begin
                m_axis_tready <= 1'b0;
                stall = $urandom_range(17);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(logic [383:0] d);
        if (!calm && $urandom_range(5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        s_axis_tdata  <= d;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic write_reg(logic [rti_pkg::IDX_WIDTH-1:0] idx, logic [31:0] v);
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            rti_pkg::REG_DIR_X:   dir_x = v;
            rti_pkg::REG_DIR_Y:   dir_y = v;
            rti_pkg::REG_DIR_Z:   dir_z = v;
            rti_pkg::REG_EPSILON: eps = v[30:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        stop_sending();
        while (hit_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [383:0] pack(int v[12]);
        logic [383:0] d;
        foreach (v[k]) d[k*32+:32] = v[k];
        return d;
    endfunction

    function automatic logic [383:0] noise_item();
        logic [383:0] d;
        for (int k = 0; k < rti_pkg::IN_FIELDS; k++) d[k*32+:32] = $urandom;
        return d;
    endfunction

    // aim the ray at a random point of a random triangle, from either side
    function automatic logic [383:0] aimed_item();
        int v[12];
        int w1, w2, s;
        for (int k = 3; k < 12; k++) v[k] = 16 * $signed($urandom_range(0, 131072) - 65536);
        w1 = $urandom_range(16);
        w2 = $urandom_range(16 - w1);
        s  = $signed($urandom_range(7)) - 2;
        for (int k = 0; k < 3; k++)
            v[k] = v[3+k] + (w1 * (v[6+k] - v[3+k]) + w2 * (v[9+k] - v[3+k])) / 16;
        v[0] -= s * $signed(dir_x);
        v[1] -= s * $signed(dir_y);
        v[2] -= s * $signed(dir_z);
        return pack(v);
    endfunction

    task automatic test_directed();
        int tri5[9] = '{5*Q, 0, 0, 5*Q, Q, 0, 5*Q, 0, Q};
        int org[8][3] = '{'{0, Q/4, Q/4}, '{0, 0, 0}, '{0, Q, 0}, '{0, Q/2, Q/2},
                          '{0, -Q/10, Q/5}, '{10*Q, Q/5, Q/5}, '{0, Q/2, Q/2+1},
                          '{5*Q, Q/4, Q/4}};
        int v[12];
        for (int n = 0; n < 8; n++) begin
            for (int k = 0; k < 3; k++) v[k] = org[n][k];
            for (int k = 0; k < 9; k++) v[3+k] = tri5[k];
            send_item(pack(v));
        end
        v = '{0, 0, 0, Q, Q, Q, Q, Q, Q, 2*Q, 0, Q};
        send_item(pack(v));
        send_item({12{32'h7fffffff}});
        send_item({12{32'h80000000}});
        send_item({6{64'h80000000_7fffffff}});
        send_item({6{64'h7fffffff_80000000}});
        send_item({12{32'hffffffff}});
        send_item('0);
        drain();
    endtask

    task automatic test_zero_eps();
        int v[12];
        write_reg(rti_pkg::REG_EPSILON, 32'h0);
        for (int k = rti_pkg::REG_EPSILON + 1; k < 2**rti_pkg::IDX_WIDTH; k++)
            write_reg(rti_pkg::IDX_WIDTH'(k), 32'hffffffff);
        v = '{5*Q, Q/4, Q/4, 5*Q, 0, 0, 5*Q, Q, 0, 5*Q, 0, Q};
        send_item(pack(v));
        v = '{0, 0, 0, Q, Q, Q, Q, Q, Q, 2*Q, 0, Q};
        send_item(pack(v));
        v = '{0, Q/4, Q/4, 5*Q, 0, 0, 5*Q, Q, 0, 5*Q, 0, Q};
        send_item(pack(v));
        drain();
    endtask

    task automatic test_random(int n, bit extreme);
        if (extreme) begin
            write_reg(rti_pkg::REG_DIR_X, 32'h7fffffff);
            write_reg(rti_pkg::REG_DIR_Y, 32'h80000000);
            write_reg(rti_pkg::REG_DIR_Z, 32'hffffffff);
            write_reg(rti_pkg::REG_EPSILON, 32'hffffffff);
        end else begin
            write_reg(rti_pkg::REG_DIR_X, $urandom_range(0, 8*Q) - 4*Q);
            write_reg(rti_pkg::REG_DIR_Y, $urandom_range(0, 8*Q) - 4*Q);
            write_reg(rti_pkg::REG_DIR_Z, $urandom_range(0, 8*Q) - 4*Q);
            write_reg(rti_pkg::REG_EPSILON, $urandom_range(0, 200));
        end
        repeat (n) send_item(($urandom_range(9) < 7) ? aimed_item() : noise_item());
        drain();
    endtask

    task automatic test_backpressure();
        write_reg(rti_pkg::REG_DIR_X, Q);
        write_reg(rti_pkg::REG_DIR_Y, Q/3);
        write_reg(rti_pkg::REG_DIR_Z, -Q/5);
        hold_req = 1;
        repeat (40) send_item(aimed_item());
        drain();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_zero_eps();
        test_random(20, 1);
        repeat (4) test_random(90, 0);
        test_backpressure();
        calm = 1;
        test_random(80, 0);
        if (errors == 0)
            $display("ray_triangle_intersect_test_unit test passed");
        else
            $display("ray_triangle_intersect_test_unit test failed");
        $finish;
    end

    initial begin
        #3ms;
        $display("ray_triangle_intersect_test_unit test failed");
        $finish;
    end
endmodule
`default_nettype wire
